[rtl/sbcm_pkg.sv]
// Shared types, constants and shape table for the sprite box collision mover.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sbcm_pkg;

  localparam int PosW     = 10;
  localparam int VelW     = 5;
  localparam int CoordW   = 12;  // holds position +/- velocity and obstacle deltas
  localparam int CfgIdxW  = 3;
  localparam int ShapeSize = 20;
  localparam int NumRects = 15;

  typedef logic [PosW-1:0]          pos_t;
  typedef logic signed [VelW-1:0]   vel_t;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CfgIdxW-1:0]       cfg_idx_t;

  typedef enum logic {
    OpMove  = 1'b0,
    OpPlace = 1'b1
  } op_e;

  // Register indexes
  localparam cfg_idx_t CfgObstacleX  = 3'd0;
  localparam cfg_idx_t CfgObstacleY  = 3'd1;
  localparam cfg_idx_t CfgScreenW    = 3'd2;
  localparam cfg_idx_t CfgScreenH    = 3'd3;

  localparam pos_t ObstacleXRst = 10'd10;
  localparam pos_t ObstacleYRst = 10'd10;
  localparam pos_t ScreenWRst   = 10'd640;
  localparam pos_t ScreenHRst   = 10'd480;
  localparam pos_t SpriteXRst   = 10'd50;
  localparam pos_t SpriteYRst   = 10'd50;

  typedef struct packed {
    pos_t obstacle_x;
    pos_t obstacle_y;
    pos_t area_w;
    pos_t area_h;
  } cfg_t;

  // Round sprite as stacked, horizontally centered rectangles
  localparam int RectW [NumRects] = '{4, 10, 12, 14, 16, 18, 18, 20, 18, 18, 16, 14, 12, 10, 4};
  localparam int RectH [NumRects] = '{1, 1, 1, 1, 1, 1, 2, 4, 2, 1, 1, 1, 1, 1, 1};

  function automatic int rect_left(int i);
    return (ShapeSize - RectW[i]) / 2;
  endfunction

  function automatic int rect_top(int i);
    int acc;
    acc = 0;
    for (int k = 0; k < NumRects; k++) begin
      if (k < i) acc = acc + RectH[k];
    end
    return acc;
  endfunction

endpackage

[rtl/sbcm_req_if.sv]
// Request channel: valid/ready handshake carrying one move or place request.
// Depends on sbcm_pkg.
`timescale 1ns / 1ps

interface sbcm_req_if;
  import sbcm_pkg::*;

  logic valid;
  logic ready;
  op_e  op;
  vel_t x_vel;
  vel_t y_vel;
  pos_t place_x;
  pos_t place_y;

  modport source (output valid, op, x_vel, y_vel, place_x, place_y, input ready);
  modport sink   (input valid, op, x_vel, y_vel, place_x, place_y, output ready);
endinterface

[rtl/sbcm_rsp_if.sv]
// Result channel: valid/ready handshake carrying new position and flags.
// Depends on sbcm_pkg.
`timescale 1ns / 1ps

interface sbcm_rsp_if;
  import sbcm_pkg::*;

  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  logic collided;
  logic x_reverted;
  logic y_reverted;

  modport source (output valid, pos_x, pos_y, collided, x_reverted, y_reverted,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, collided, x_reverted, y_reverted,
                  output ready);
endinterface

[rtl/sbcm_cfg_regs.sv]
// Configuration register file: obstacle position and screen bounds.
// Depends on sbcm_pkg.
`timescale 1ns / 1ps

module sbcm_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  sbcm_pkg::cfg_idx_t cfg_idx_i,
  input  sbcm_pkg::pos_t    cfg_wdata_i,
  output sbcm_pkg::cfg_t    cfg_o
);
  import sbcm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.obstacle_x <= ObstacleXRst;
      cfg_q.obstacle_y <= ObstacleYRst;
      cfg_q.area_w     <= ScreenWRst;
      cfg_q.area_h     <= ScreenHRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgObstacleX: cfg_q.obstacle_x <= cfg_wdata_i;
        CfgObstacleY: cfg_q.obstacle_y <= cfg_wdata_i;
        CfgScreenW:   cfg_q.area_w     <= cfg_wdata_i;
        CfgScreenH:   cfg_q.area_h     <= cfg_wdata_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/sbcm_collide.sv]
// Shape-vs-shape overlap test: all rectangle pairs checked against the
// sprite-to-obstacle offset. Depends on sbcm_pkg.
`timescale 1ns / 1ps

module sbcm_collide (
  input  sbcm_pkg::coord_t dx_i,  // moved sprite left minus obstacle left
  input  sbcm_pkg::coord_t dy_i,  // moved sprite top minus obstacle top
  output logic             hit_o
);
  import sbcm_pkg::*;

  logic [NumRects*NumRects-1:0] pair_hit;

  // Strict overlap of rect i (sprite) and rect j (obstacle) reduces to an
  // open interval on each offset; the bounds are elaboration constants.
  for (genvar i = 0; i < NumRects; i++) begin : g_a
    for (genvar j = 0; j < NumRects; j++) begin : g_b
      localparam coord_t XLo = coord_t'(rect_left(j) - rect_left(i) - RectW[i]);
      localparam coord_t XHi = coord_t'(rect_left(j) + RectW[j] - rect_left(i));
      localparam coord_t YLo = coord_t'(rect_top(j) - rect_top(i) - RectH[i]);
      localparam coord_t YHi = coord_t'(rect_top(j) + RectH[j] - rect_top(i));

      assign pair_hit[i*NumRects+j] = (dx_i > XLo) && (dx_i < XHi) &&
                                      (dy_i > YLo) && (dy_i < YHi);
    end
  end

  assign hit_o = |pair_hit;

endmodule

[rtl/sprite_box_collision_move.sv]
// Sprite box collision mover: top level with request register, position
// state, step logic and result register. Depends on sbcm_pkg, sbcm_req_if,
// sbcm_rsp_if, sbcm_cfg_regs and sbcm_collide.
`timescale 1ns / 1ps

// Usage
//   req (sink): one request per handshake. op = move steps the sprite by
//     x_vel/y_vel (signed); op = place sets it to place_x/place_y.
//   rsp (source): one result per request, in order: position after the
//     request, collided flag and per-axis revert flags.
//   cfg: write-only; cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//     (0 obstacle x, 1 obstacle y, 2 screen width, 3 screen height).
//     Unmapped indexes are dropped. Write only while no request is in flight.
// Timing
//   A request lands in the input register at its handshake edge; the step is then
//   computed and loaded into the result register once that register is empty or
//   being taken, which raises rsp.valid. Throughput is one request per cycle
//   while rsp.ready stays high: the position register feeds its own adder,
//   bounds compare and 225-pair overlap test combinationally.
// Reset
//   Sprite at (50,50), obstacle at (10,10), screen 640x480, both pipeline
//   registers empty.
// Backpressure
//   With rsp.ready low the result holds; one more request waits in the input
//   register, then req.ready drops until the result is taken.

module sprite_box_collision_move (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  sbcm_pkg::cfg_idx_t cfg_idx_i,
  input  sbcm_pkg::pos_t     cfg_wdata_i,
  sbcm_req_if.sink           req,
  sbcm_rsp_if.source         rsp
);
  import sbcm_pkg::*;

  cfg_t cfg;

  sbcm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // ---- input register ----
  logic in_vld_q;
  op_e  in_op_q;
  vel_t in_xv_q, in_yv_q;
  pos_t in_px_q, in_py_q;

  logic out_vld_q;
  logic fire;  // step executes this cycle

  assign fire      = in_vld_q && (!out_vld_q || rsp.ready);
  assign req.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req.ready) begin
      in_vld_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      in_op_q <= req.op;
      in_xv_q <= req.x_vel;
      in_yv_q <= req.y_vel;
      in_px_q <= req.place_x;
      in_py_q <= req.place_y;
    end
  end

  // ---- step logic ----
  pos_t   sx_q, sy_q, sx_d, sy_d;
  coord_t nx, ny, dx, dy;
  logic   hit, x_out, y_out;
  logic   hit_d, xr_d, yr_d;

  assign nx = coord_t'({2'b00, sx_q}) + coord_t'(in_xv_q);
  assign ny = coord_t'({2'b00, sy_q}) + coord_t'(in_yv_q);
  assign dx = nx - coord_t'({2'b00, cfg.obstacle_x});
  assign dy = ny - coord_t'({2'b00, cfg.obstacle_y});

  sbcm_collide u_collide (
    .dx_i  (dx),
    .dy_i  (dy),
    .hit_o (hit)
  );

  // axis leaves the screen: below zero or right/bottom edge past the bound
  assign x_out = (nx < coord_t'(0)) ||
                 ((nx + coord_t'(ShapeSize)) > coord_t'({2'b00, cfg.area_w}));
  assign y_out = (ny < coord_t'(0)) ||
                 ((ny + coord_t'(ShapeSize)) > coord_t'({2'b00, cfg.area_h}));

  always_comb begin
    sx_d  = sx_q;
    sy_d  = sy_q;
    hit_d = 1'b0;
    xr_d  = 1'b0;
    yr_d  = 1'b0;
    unique case (in_op_q)
      OpPlace: begin
        sx_d = in_px_q;
        sy_d = in_py_q;
      end
      OpMove: begin
        hit_d = hit;
        xr_d  = x_out || hit;  // a collision undoes both axes
        yr_d  = y_out || hit;
        if (!xr_d) sx_d = nx[PosW-1:0];
        if (!yr_d) sy_d = ny[PosW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= SpriteXRst;
      sy_q <= SpriteYRst;
    end else if (fire) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  // ---- result register ----
  pos_t out_x_q, out_y_q;
  logic out_hit_q, out_xr_q, out_yr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (rsp.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_x_q   <= sx_d;
      out_y_q   <= sy_d;
      out_hit_q <= hit_d;
      out_xr_q  <= xr_d;
      out_yr_q  <= yr_d;
    end
  end

  assign rsp.valid      = out_vld_q;
  assign rsp.pos_x      = out_x_q;
  assign rsp.pos_y      = out_y_q;
  assign rsp.collided   = out_hit_q;
  assign rsp.x_reverted = out_xr_q;
  assign rsp.y_reverted = out_yr_q;

  // ---- assertions ----
  a_hit_reverts_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.collided |-> rsp.x_reverted && rsp.y_reverted)
    else $error("collision without revert on both axes");

  a_rsp_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.pos_x == sx_q) && (rsp.pos_y == sy_q))
    else $error("pending result disagrees with sprite position");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !fire |=> in_vld_q && $stable(in_px_q) && $stable(in_op_q))
    else $error("stalled request lost or overwritten");

  a_place_sets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_op_q == OpPlace) |=>
      (sx_q == $past(in_px_q)) && (sy_q == $past(in_py_q)) &&
      !rsp.collided && !rsp.x_reverted && !rsp.y_reverted)
    else $error("place request did not set position cleanly");

endmodule

[verif/sbcm_step_checker.sv]
// Checker for the sprite box collision mover: watches the request, result and
// register write ports, predicts every result and compares it field by field.
// Depends on sbcm_pkg, sbcm_req_if and sbcm_rsp_if.
`timescale 1ns / 1ps

module sbcm_step_checker
  import sbcm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  cfg_idx_t cfg_idx_i,
  input  pos_t     cfg_wdata_i,
  sbcm_req_if      req,
  sbcm_rsp_if      rsp,
  output int       errors_o,
  output int       pending_o
);

  localparam int SpriteSize = 20;
  localparam int NumRows    = 15;
  // Round sprite: row widths and heights, top to bottom, rows centered
  localparam int RowW [NumRows] = '{4, 10, 12, 14, 16, 18, 18, 20, 18, 18, 16, 14, 12, 10, 4};
  localparam int RowH [NumRows] = '{1, 1, 1, 1, 1, 1, 2, 4, 2, 1, 1, 1, 1, 1, 1};

  localparam pos_t HomeX      = 10'd50;
  localparam pos_t HomeY      = 10'd50;
  localparam pos_t ObstHomeX  = 10'd10;
  localparam pos_t ObstHomeY  = 10'd10;
  localparam pos_t ScreenHomeW = 10'd640;
  localparam pos_t ScreenHomeH = 10'd480;

  typedef struct packed {
    pos_t pos_x;
    pos_t pos_y;
    logic collided;
    logic x_reverted;
    logic y_reverted;
  } step_result_t;

  pos_t obst_x, obst_y, scr_w, scr_h;
  pos_t sprite_x, sprite_y;
  step_result_t expected_steps[$];
  int err_cnt;

  // Strict overlap of every row pair of two sprites at (ax,ay) and (bx,by)
  function automatic logic blobs_overlap(int ax, int ay, int bx, int by);
    int ta, tb, la, lb;
    logic hit;
    hit = 1'b0;
    ta = ay;
    for (int i = 0; i < NumRows; i++) begin
      la = ax + (SpriteSize - RowW[i]) / 2;
      tb = by;
      for (int j = 0; j < NumRows; j++) begin
        lb = bx + (SpriteSize - RowW[j]) / 2;
        if (ta < tb + RowH[j] && tb < ta + RowH[i] &&
            la < lb + RowW[j] && lb < la + RowW[i]) hit = 1'b1;
        tb = tb + RowH[j];
      end
      ta = ta + RowH[i];
    end
    return hit;
  endfunction

  function automatic step_result_t predict_step(op_e op, vel_t xv, vel_t yv,
                                                pos_t px, pos_t py);
    step_result_t r;
    int nx, ny;
    r = '0;
    if (op == OpPlace) begin
      r.pos_x = px;
      r.pos_y = py;
    end else begin
      nx = int'(sprite_x) + int'(xv);
      ny = int'(sprite_y) + int'(yv);
      r.collided   = blobs_overlap(nx, ny, int'(obst_x), int'(obst_y));
      r.x_reverted = nx < 0 || nx + SpriteSize > int'(scr_w) || r.collided;
      r.y_reverted = ny < 0 || ny + SpriteSize > int'(scr_h) || r.collided;
      r.pos_x = r.x_reverted ? sprite_x : pos_t'(nx);
      r.pos_y = r.y_reverted ? sprite_y : pos_t'(ny);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    step_result_t want, got;
    if (!rst_ni) begin
      obst_x   = ObstHomeX;
      obst_y   = ObstHomeY;
      scr_w    = ScreenHomeW;
      scr_h    = ScreenHomeH;
      sprite_x = HomeX;
      sprite_y = HomeY;
      expected_steps.delete();
      err_cnt  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgObstacleX: obst_x = cfg_wdata_i;
          CfgObstacleY: obst_y = cfg_wdata_i;
          CfgScreenW:   scr_w  = cfg_wdata_i;
          CfgScreenH:   scr_h  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.pos_x, rsp.pos_y, rsp.collided, rsp.x_reverted, rsp.y_reverted};
        if (expected_steps.size() == 0) begin
          $error("result with no request outstanding: pos %0d,%0d", got.pos_x, got.pos_y);
          err_cnt++;
        end else begin
          want = expected_steps.pop_front();
          if (got.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
            err_cnt++;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
            err_cnt++;
          end
          if (got.collided !== want.collided) begin
            $error("collided: expected %0b, got %0b", want.collided, got.collided);
            err_cnt++;
          end
          if (got.x_reverted !== want.x_reverted) begin
            $error("x_reverted: expected %0b, got %0b", want.x_reverted, got.x_reverted);
            err_cnt++;
          end
          if (got.y_reverted !== want.y_reverted) begin
            $error("y_reverted: expected %0b, got %0b", want.y_reverted, got.y_reverted);
            err_cnt++;
          end
        end
      end
      if (req.valid && req.ready) begin
        want = predict_step(req.op, req.x_vel, req.y_vel, req.place_x, req.place_y);
        sprite_x = want.pos_x;
        sprite_y = want.pos_y;
        expected_steps.push_back(want);
      end
    end
    errors_o  <= err_cnt;
    pending_o <= expected_steps.size();
  end

endmodule

[verif/sprite_box_collision_move_tb.sv]
// Testbench top for the sprite box collision mover: clock, reset, request
// stimulus, result backpressure, register writes, watchdog and verdict.
// Depends on sbcm_pkg, sbcm_req_if, sbcm_rsp_if, sbcm_step_checker and the RTL.
`timescale 1ns / 1ps

module sprite_box_collision_move_tb;
  import sbcm_pkg::*;

  localparam int ClkPeriod       = 20;
  localparam int ResetCycles     = 9;
  localparam int ItemsPerScene   = 155;  // nine scenes, about 1400 requests in all
  localparam int NumRandomScenes = 6;
  localparam int MaxGap          = 10;
  localparam int IdleLimit       = 2000; // far above longest stall plus longest gap
  localparam int SettleCycles    = 4;
  localparam int TailCycles      = 8;
  localparam cfg_idx_t CfgUnmapped = 3'd6;  // no register behind this index

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_we_i;
  cfg_idx_t cfg_idx_i;
  pos_t     cfg_wdata_i;
  int       errors;
  int       pending;

  // Scene as last written; used to aim placements near the obstacle
  int scene_ox, scene_oy;
  int burst_left;

  sbcm_req_if req ();
  sbcm_rsp_if rsp ();

  sprite_box_collision_move dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req),
    .rsp         (rsp)
  );

  sbcm_step_checker u_step_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req),
    .rsp         (rsp),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Result backpressure. The receiver moves through random moods:
  // always ready, frequent short stalls, rare long stalls.
  initial begin : result_stalls
    int stall_left, mood_left, stall_pct, stall_max;
    stall_left = 0;
    mood_left  = 0;
    stall_pct  = 0;
    stall_max  = 0;
    rsp.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (mood_left == 0) begin
        mood_left = $urandom_range(50, 300);
        case ($urandom_range(0, 2))
          0: begin
            stall_pct = 0;
            stall_max = 0;
          end
          1: begin
            stall_pct = 35;
            stall_max = 2;
          end
          default: begin
            stall_pct = 6;
            stall_max = 30;
          end
        endcase
      end else begin
        mood_left--;
      end
      if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        rsp.ready <= 1'b0;
        stall_left = $urandom_range(0, stall_max);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too many cycles without any handshake means a hang or a lost result
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles = 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  // One request; returns at the edge that accepted it, or after the gap when a
  // burst ends. Valid stays high through a burst, then drops for a random gap.
  task automatic send_req(op_e op, vel_t xv, vel_t yv, pos_t px, pos_t py);
    req.valid   <= 1'b1;
    req.op      <= op;
    req.x_vel   <= xv;
    req.y_vel   <= yv;
    req.place_x <= px;
    req.place_y <= py;
    do @(posedge clk_i); while (!req.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, MaxGap)) @(posedge clk_i);
      // mostly short bursts, now and then a long run with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Move request; the unused place fields carry random bits
  task automatic move(int dx, int dy);
    send_req(OpMove, vel_t'(dx), vel_t'(dy), pos_t'($urandom), pos_t'($urandom));
  endtask

  // Place request; the unused velocity fields carry random bits
  task automatic place(int px, int py);
    send_req(OpPlace, vel_t'($urandom), vel_t'($urandom), pos_t'(px), pos_t'(py));
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, pos_t val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_scene(int ox, int oy, int sw, int sh);
    scene_ox = ox;
    scene_oy = oy;
    write_reg(CfgObstacleX, pos_t'(ox));
    write_reg(CfgObstacleY, pos_t'(oy));
    write_reg(CfgScreenW, pos_t'(sw));
    write_reg(CfgScreenH, pos_t'(sh));
  endtask

  // Random traffic: mostly moves, some placements near the obstacle so that
  // collisions and near misses are common, a few placements anywhere.
  task automatic random_traffic(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        place(scene_ox + int'($urandom_range(0, 50)) - 25,
              scene_oy + int'($urandom_range(0, 50)) - 25);
      end else if (pick < 15) begin
        place(int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)));
      end else if (pick < 55) begin
        // small steps creep up on the obstacle and the walls
        move(int'($urandom_range(0, 4)) - 2, int'($urandom_range(0, 4)) - 2);
      end else begin
        move(int'($urandom_range(0, 31)) - 16, int'($urandom_range(0, 31)) - 16);
      end
    end
  endtask

  initial begin : stimulus
    int sw, sh;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgObstacleX;
    cfg_wdata_i = '0;
    req.valid   = 1'b0;
    req.op      = OpMove;
    req.x_vel   = '0;
    req.y_vel   = '0;
    req.place_x = '0;
    req.place_y = '0;
    scene_ox    = 10;
    scene_oy    = 10;
    burst_left  = 0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset scene: obstacle at (10,10), screen 640x480,
    // sprite starting at (50,50).
    move(0, 0);
    move(15, 15);       // largest positive step on both axes
    move(-16, -16);     // largest negative step on both axes
    move(-16, -16);
    move(-16, 0);
    move(0, -16);       // runs into the obstacle: both axes undone
    place(30, 10);      // edges touching: strict overlap says no hit
    move(0, 0);
    move(-1, 0);        // one pixel of overlap
    place(27, 27);      // diagonal, rounded corners may miss each other
    move(0, 0);
    place(10, 10);      // sprite right on top of the obstacle
    move(0, 0);
    place(0, 0);        // place ignores the obstacle
    move(-16, 15);      // left of the screen on x
    move(15, -16);      // above the screen on y
    place(620, 460);    // exact fit in the bottom right corner
    move(0, 0);
    move(1, 1);         // one pixel past both bounds
    move(-1, -1);
    place(1023, 1023);  // largest position, beyond the screen
    move(-16, -16);
    place(0, 1023);
    move(15, 0);
    settle();

    // Lower extremes: tiny screen with the obstacle filling it, plus a write
    // to an index with no register behind it
    set_scene(0, 0, 20, 20);
    write_reg(CfgUnmapped, pos_t'($urandom));
    random_traffic(ItemsPerScene);
    settle();

    // Upper extremes
    set_scene(1023, 1023, 1023, 1023);
    random_traffic(ItemsPerScene);
    settle();

    // Screen bounds below the sprite size: every move is undone on both axes
    set_scene(500, 300, 0, 19);
    random_traffic(ItemsPerScene);
    settle();

    // Random scenes, mostly small screens so the walls are hit often
    for (int s = 0; s < NumRandomScenes; s++) begin
      sw = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 1023) : $urandom_range(20, 160);
      sh = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 1023) : $urandom_range(20, 160);
      set_scene($urandom_range(0, sw), $urandom_range(0, sh), sw, sh);
      random_traffic(ItemsPerScene);
      settle();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
